// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define AQ_ASSERT_IMPL(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication, ignored while reset is high.
`define AQ_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ===== sv/alq_pkg.sv =====
// ----------------------------------------------------------------------------
// alq_pkg
// Types, codes and fixed-point helpers of the Legendre quadrature block.
// ----------------------------------------------------------------------------
package alq_pkg;

   localparam int MAX_DEGREE_DEF = 10;
   localparam int FRAC_BITS_DEF  = 30;
   localparam int REG_W          = 4;   // degree / order register width
   localparam int K_W            = 5;   // small integer factor width

   localparam logic CFG_DEGREE = 1'b0;
   localparam logic CFG_ORDER  = 1'b1;

   typedef enum logic [3:0] {
      DP_NOP, DP_LOAD, DP_ZERO, DP_SQRT, DP_SCALE, DP_MUL, DP_PMM,
      DP_FIRST, DP_REC_A, DP_REC_B, DP_DIV, DP_ACC
   } dp_op_type;

   typedef enum logic [1:0] {
      MS_A_S, MS_X_V1, MS_W_V1
   } mul_sel_type;

   typedef struct packed {
      dp_op_type          op;
      mul_sel_type        sel;
      logic [K_W-1:0]     kval;
   } dp_cmd_type;

   typedef struct packed {
      logic sqrt_done;
      logic mul_done;
      logic div_done;
   } dp_status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_SQRT, S_PMM_A, S_PMM_WAIT, S_LM, S_F_WAIT,
      S_R_MUL, S_R_WAIT, S_R_B, S_R_DIV, S_R_DWAIT, S_WMUL, S_W_WAIT, S_OUT
   } state_type;

   function automatic logic [63:0] mag_of(input logic signed [63:0] v);
      mag_of = v[63] ? (64'd0 - 64'(v)) : 64'(v);
   endfunction

   function automatic logic signed [63:0] sat_from_mag(input logic [63:0] mag,
                                                       input logic neg,
                                                       input logic over);
      if (neg) begin
         if (over || mag[63]) sat_from_mag = {1'b1, 63'd0};
         else sat_from_mag = 64'd0 - mag;
      end else begin
         if (over || mag[63]) sat_from_mag = {1'b0, {63{1'b1}}};
         else sat_from_mag = mag;
      end
   endfunction

   function automatic logic signed [63:0] sat_neg(input logic signed [63:0] v);
      if (v == {1'b1, 63'd0}) sat_neg = {1'b0, {63{1'b1}}};
      else sat_neg = -v;
   endfunction

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] r;
      r = a + b;
      if (!a[63] && !b[63] && r[63]) sat_add = {1'b0, {63{1'b1}}};
      else if (a[63] && b[63] && !r[63]) sat_add = {1'b1, 63'd0};
      else sat_add = r;
   endfunction

   function automatic logic signed [63:0] mul_int(input logic signed [63:0] v,
                                                  input logic [K_W-1:0] k);
      logic [63+K_W:0] prod;
      prod = {{K_W{1'b0}}, mag_of(v)} * {64'd0, k};
      mul_int = sat_from_mag(prod[63:0], v[63], |prod[63+K_W:64]);
   endfunction

endpackage

// ===== sv/alq_ctrl.sv =====
// ----------------------------------------------------------------------------
// alq_ctrl
// Sequencer: config registers, loop counters and datapath commands.
// ----------------------------------------------------------------------------
module alq_ctrl
   import alq_pkg::*;
#(
   parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [REG_W-1:0]  csr_data,
   output dp_cmd_type        cmd,
   input  dp_status_type     status
);

   localparam logic [REG_W-1:0] MAX_L = REG_W'(MAX_DEGREE);

   state_type         state_ff, state_in;
   logic [REG_W-1:0]  degree_ff, order_ff, cnt_ff, cnt_in;
   logic              valid_ff, valid_in;
   logic [REG_W-1:0]  l_eff;
   logic [K_W-1:0]    cnt_k, m_k, l_k;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = valid_ff;
   assign l_eff = (degree_ff > MAX_L) ? MAX_L : degree_ff;
   assign cnt_k = K_W'(cnt_ff);
   assign m_k   = K_W'(order_ff);
   assign l_k   = K_W'(l_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         valid_ff  <= 1'b0;
         degree_ff <= '0;
         order_ff  <= '0;
         cnt_ff    <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CFG_DEGREE) degree_ff <= csr_data;
            else order_ff <= csr_data;
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      valid_in   = valid_ff && !rsp_tready;
      req_tready = 1'b0;
      cmd.op     = DP_NOP;
      cmd.sel    = MS_X_V1;
      cmd.kval   = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = DP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cnt_in = '0;
            if (order_ff > l_eff) begin
               cmd.op   = DP_ZERO;
               state_in = S_WMUL;
            end else begin
               cmd.op   = DP_SQRT;
               state_in = S_SQRT;
            end
         end
         S_SQRT: if (status.sqrt_done) begin
            state_in = (order_ff == '0) ? S_LM : S_PMM_A;
         end
         S_PMM_A: begin
            // a = v1 * (2k+1), then start a * s
            cmd.op   = DP_SCALE;
            cmd.kval = K_W'({cnt_k[K_W-2:0], 1'b1});
            state_in = S_PMM_WAIT;
         end
         S_PMM_WAIT: begin
            if (cmd.op == DP_NOP && !status.mul_done && !status.sqrt_done) begin
               cmd.op = DP_NOP;
            end
            if (status.mul_done) begin
               cmd.op = DP_PMM;
               if (cnt_ff + 1'b1 == order_ff) state_in = S_LM;
               else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = S_PMM_A;
               end
            end
         end
         S_LM: begin
            if (l_eff == order_ff) state_in = S_WMUL;
            else begin
               cmd.op   = DP_MUL;
               cmd.sel  = MS_X_V1;
               state_in = S_F_WAIT;
            end
         end
         S_F_WAIT: if (status.mul_done) begin
            cmd.op   = DP_FIRST;
            cmd.kval = K_W'({m_k[K_W-2:0], 1'b1});
            cnt_in   = order_ff + REG_W'(2);
            state_in = (m_k + K_W'(2) > l_k) ? S_WMUL : S_R_MUL;
         end
         S_R_MUL: begin
            cmd.op   = DP_MUL;
            cmd.sel  = MS_X_V1;
            state_in = S_R_WAIT;
         end
         S_R_WAIT: if (status.mul_done) begin
            cmd.op   = DP_REC_A;
            cmd.kval = K_W'({cnt_k[K_W-2:0], 1'b0}) - K_W'(1);
            state_in = S_R_B;
         end
         S_R_B: begin
            cmd.op   = DP_REC_B;
            cmd.kval = cnt_k + m_k - K_W'(1);
            state_in = S_R_DIV;
         end
         S_R_DIV: begin
            cmd.op   = DP_DIV;
            cmd.kval = cnt_k - m_k;
            state_in = S_R_DWAIT;
         end
         S_R_DWAIT: if (status.div_done) begin
            if (cnt_ff == l_eff) state_in = S_WMUL;
            else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_R_MUL;
            end
         end
         S_WMUL: begin
            cmd.op   = DP_MUL;
            cmd.sel  = MS_W_V1;
            state_in = S_W_WAIT;
         end
         S_W_WAIT: if (status.mul_done) state_in = S_OUT;
         S_OUT: if (!valid_ff || rsp_tready) begin
            cmd.op   = DP_ACC;
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // the product with s starts in the same cycle as the scale step
      if (state_ff == S_PMM_A) begin
         cmd.sel = MS_A_S;
      end
   end

endmodule

// ===== sv/alq_datapath.sv =====
// ----------------------------------------------------------------------------
// alq_datapath
// Value registers, shared 64x64 multiplier (32x32 per cycle), bit-serial
// square root and divider, accumulator and result register.
// ----------------------------------------------------------------------------
module alq_datapath
   import alq_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   input  logic signed [31:0]  point,
   input  logic [31:0]         weight,
   input  logic                is_last,
   output logic signed [63:0]  poly_value,
   output logic signed [63:0]  weighted_sum,
   output logic                sum_done
);

   localparam int SQW = 2 * FRAC_BITS + 2;
   localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
   localparam logic [SQW-1:0] ONE_SQ = SQW'(1) << (2 * FRAC_BITS);
   localparam logic [127:0] RND = 128'd1 << (FRAC_BITS - 1);

   logic signed [63:0] x_ff, w_ff, s_ff, v1_ff, v2_ff, a_ff, t_ff, p_ff, acc_ff;
   logic signed [63:0] x_ext, x_clamp, sum_new;
   logic               last_ff;
   logic [63:0]        ax_full;
   logic [FRAC_BITS:0] ax;
   logic [SQW-1:0]     sq, rem_ff, root_ff, bit_ff, trial;
   logic               sq_run_ff;
   // multiplier
   logic [63:0]        ma_ff, mb_ff;
   logic               mneg_ff, mrun_ff;
   logic [2:0]         mcnt_ff;
   logic [127:0]       prod_ff, prod_rnd;
   logic [63:0]        pp;
   logic signed [63:0] opa, opb;
   // divider
   logic [63:0]        dq_ff;
   logic [K_W-1:0]     dd_ff, drem_ff;
   logic [K_W:0]       dr2;
   logic               dneg_ff, drun_ff;
   logic [6:0]         dcnt_ff;
   logic [63:0]        dquot;

   assign x_ext   = 64'(point);
   assign x_clamp = (x_ext > ONE) ? ONE : ((x_ext < -ONE) ? -ONE : x_ext);
   assign ax_full = mag_of(x_ff);
   assign ax      = ax_full[FRAC_BITS:0];
   assign sq      = SQW'(ax) * SQW'(ax);
   assign trial   = root_ff + bit_ff;

   always_comb begin
      case (cmd.sel)
         MS_A_S:  begin opa = a_ff; opb = s_ff;  end
         MS_W_V1: begin opa = w_ff; opb = v1_ff; end
         default: begin opa = x_ff; opb = v1_ff; end
      endcase
   end

   assign pp       = 64'(ma_ff[32*mcnt_ff[0] +: 32]) * 64'(mb_ff[32*mcnt_ff[1] +: 32]);
   assign prod_rnd = prod_ff + RND;
   assign dr2      = {drem_ff, dq_ff[63]};
   assign dquot    = dq_ff + 64'({drem_ff, 1'b0} >= {1'b0, dd_ff});
   assign sum_new  = sat_add(acc_ff, p_ff);

   // product is in p_ff while mul_done is high
   assign status.sqrt_done = sq_run_ff && (bit_ff == '0);
   assign status.mul_done  = mrun_ff && (mcnt_ff == 3'd5);
   assign status.div_done  = drun_ff && (dcnt_ff == 7'd64);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_run_ff <= 1'b0;
         mrun_ff   <= 1'b0;
         drun_ff   <= 1'b0;
         acc_ff    <= '0;
      end else begin
         case (cmd.op)
            DP_LOAD: begin
               x_ff    <= x_clamp;
               w_ff    <= 64'(weight);
               last_ff <= is_last;
               v1_ff   <= ONE;
            end
            DP_ZERO:  v1_ff <= '0;
            DP_SQRT: begin
               rem_ff    <= ONE_SQ - sq;
               root_ff   <= '0;
               bit_ff    <= ONE_SQ;
               sq_run_ff <= 1'b1;
            end
            DP_SCALE: a_ff <= mul_int(v1_ff, cmd.kval);
            DP_PMM:   v1_ff <= sat_neg(p_ff);
            DP_FIRST: begin
               v2_ff <= v1_ff;
               v1_ff <= mul_int(p_ff, cmd.kval);
            end
            DP_REC_A: a_ff <= mul_int(p_ff, cmd.kval);
            DP_REC_B: t_ff <= sat_add(a_ff, sat_neg(mul_int(v2_ff, cmd.kval)));
            DP_DIV: begin
               dq_ff   <= mag_of(t_ff);
               dneg_ff <= t_ff[63];
               dd_ff   <= cmd.kval;
               drem_ff <= '0;
               dcnt_ff <= '0;
               drun_ff <= 1'b1;
            end
            DP_ACC: begin
               poly_value   <= v1_ff;
               weighted_sum <= sum_new;
               sum_done     <= last_ff;
               acc_ff       <= last_ff ? 64'sd0 : sum_new;
            end
            default: ;
         endcase

         // PMM_A issues the scale step; its product with s starts in the same cycle
         if (cmd.op == DP_MUL || cmd.op == DP_SCALE) begin
            ma_ff   <= mag_of(cmd.op == DP_SCALE ? mul_int(v1_ff, cmd.kval) : opa);
            mb_ff   <= mag_of(opb);
            mneg_ff <= (cmd.op == DP_SCALE ? v1_ff[63] : opa[63]) ^ opb[63];
            prod_ff <= '0;
            mcnt_ff <= '0;
            mrun_ff <= 1'b1;
         end else if (mrun_ff) begin
            if (mcnt_ff == 3'd5) begin
               mrun_ff <= 1'b0;
            end else if (mcnt_ff == 3'd4) begin
               p_ff    <= sat_from_mag(prod_rnd[FRAC_BITS+63:FRAC_BITS], mneg_ff,
                                       |prod_rnd[127:FRAC_BITS+64]);
               mcnt_ff <= 3'd5;
            end else begin
               case (2'(mcnt_ff[0]) + 2'(mcnt_ff[1]))
                  2'd0:    prod_ff <= prod_ff + {64'd0, pp};
                  2'd1:    prod_ff <= prod_ff + {32'd0, pp, 32'd0};
                  default: prod_ff <= prod_ff + {pp, 64'd0};
               endcase
               mcnt_ff <= mcnt_ff + 3'd1;
            end
         end

         if (sq_run_ff && cmd.op != DP_SQRT) begin
            if (bit_ff == '0) begin
               s_ff      <= 64'(root_ff);
               sq_run_ff <= 1'b0;
            end else begin
               if (rem_ff >= trial) begin
                  rem_ff  <= rem_ff - trial;
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
            end
         end

         if (drun_ff && cmd.op != DP_DIV) begin
            if (dcnt_ff == 7'd64) begin
               v2_ff   <= v1_ff;
               v1_ff   <= sat_from_mag(dquot, dneg_ff, 1'b0);
               drun_ff <= 1'b0;
            end else begin
               if (dr2 >= {1'b0, dd_ff}) begin
                  drem_ff <= K_W'(dr2 - {1'b0, dd_ff});
                  dq_ff   <= {dq_ff[62:0], 1'b1};
               end else begin
                  drem_ff <= dr2[K_W-1:0];
                  dq_ff   <= {dq_ff[62:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff + 7'd1;
            end
         end
      end
   end

endmodule

// ===== sv/associated_legendre_quadrature.sv =====
// ----------------------------------------------------------------------------
// associated_legendre_quadrature
// Evaluates P_l^m(x) per quadrature point and accumulates weight * value.
// ----------------------------------------------------------------------------
// One item at a time. Per point: setup, sqrt(1-x^2) (bit-serial root), per
// order step one small-integer scale plus a 64x64 product made of four 32x32
// partial products, a rounding step and a result step, then the first degree
// step, each further degree step (product, two scale steps, bit-serial divide
// by (j-m)), and the weighted accumulate and result load. Degree steps run
// only for order m < degree l; when m > l the value is zero and only the
// weighted accumulate runs. The result load waits while an earlier result is
// still unaccepted. The serial divider dominates for high degrees.
// The result register lets the next point be taken while a result waits; the
// accumulator clears when the result of a point marked last is loaded.
module associated_legendre_quadrature
   import alq_pkg::*;
#(
   parameter int MAX_DEGREE = MAX_DEGREE_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [63:0]       req_tdata,   // [31:0] point, [63:32] weight
   input  logic              req_tlast,   // is_last
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [127:0]      rsp_tdata,   // [63:0] poly_value, [127:64] weighted_sum
   output logic              rsp_tlast,   // sum_done
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,   // 0 degree, 1 order
   input  logic [REG_W-1:0]  csr_data
);

   dp_cmd_type         cmd;
   dp_status_type      status;
   logic signed [63:0] poly_value, weighted_sum;

   alq_ctrl #(.MAX_DEGREE(MAX_DEGREE)) u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .csr_valid, .csr_ready, .csr_index, .csr_data, .cmd, .status
   );

   alq_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock, .reset, .cmd, .status,
      .point(req_tdata[31:0]), .weight(req_tdata[63:32]), .is_last(req_tlast),
      .poly_value, .weighted_sum, .sum_done(rsp_tlast)
   );

   assign rsp_tdata = {weighted_sum, poly_value};

endmodule

// ===== sv/alq_checker.sv =====
// ----------------------------------------------------------------------------
// alq_port_checks
// Port-level checks of the Legendre quadrature block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alq_port_checks (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic csr_ready
);

   `AQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `AQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `AQ_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_tvalid && req_tready, !$rose(rsp_tvalid))
   `AQ_ASSERT_IMPL(a_csr_open, clock, reset, 1'b1, csr_ready)

endmodule

bind associated_legendre_quadrature alq_port_checks u_alq_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .csr_ready
);
